@@ sv/rhsl_pkg.sv @@
// shared types and constants for the rgb to hsl converter
// used by rhsl_div and rgb_to_hsl_converter; no dependencies
`default_nettype none

package rhsl_pkg;

	localparam int CHAN_W     = 8;
	localparam int SUM_W      = 9;
	localparam int DIFF_W     = 9;
	localparam int HUE_W      = 15;
	localparam int SAT_W      = 17;
	localparam int HUE_OFS_W  = 12;
	localparam int DIV_N_W    = 24;
	localparam int RCP_SHIFT  = 24;
	localparam int RCP_W      = 25;
	localparam int QUO_W      = 17;
	localparam int QD_W       = QUO_W + CHAN_W;
	localparam int PROD_W     = DIV_N_W + RCP_W;
	localparam int SAT_FRAC_W = 16;

	localparam int unsigned RCP_ONE = 32'd1 << RCP_SHIFT;

	localparam logic [SUM_W-1:0]   SUM_MAX        = 9'd510;
	localparam logic [DIV_N_W-1:0] HUE_SECTOR_N   = 24'd3840;
	localparam logic [HUE_W-1:0]   HUE_GREEN_BASE = 15'd7680;
	localparam logic [HUE_W-1:0]   HUE_BLUE_BASE  = 15'd15360;
	localparam logic [HUE_W-1:0]   HUE_FULL       = 15'd23040;
	localparam logic [SAT_W-1:0]   SAT_ONE        = 17'd65536;

	typedef enum logic [1:0] {
		SECTOR_RED,
		SECTOR_GREEN,
		SECTOR_BLUE
	} sector_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue_q6;
		logic [SAT_W-1:0] saturation_q16;
		logic [SUM_W-1:0] lightness_sum;
	} hsl_pixel_t;

	// load enables for the four divider stages
	typedef struct packed {
		logic tab;
		logic mul;
		logic chk;
		logic fix;
	} div_en_t;

endpackage

`default_nettype wire

@@ sv/rhsl_div.sv @@
// pipelined unsigned divider by reciprocal multiply with one-step correction
// four register stages; depends on rhsl_pkg
`default_nettype none

module rhsl_div import rhsl_pkg::*; (
	input  wire logic                clk,
	input  wire div_en_t             en,
	input  wire logic [DIV_N_W-1:0]  num,
	input  wire logic [CHAN_W-1:0]   den,
	output logic      [QUO_W-1:0]    quo
);

	logic [RCP_W-1:0]   rcp_tab [2**CHAN_W];

	logic [DIV_N_W-1:0] num_s2, num_s3, num_s4;
	logic [CHAN_W-1:0]  den_s2, den_s3, den_s4;
	logic [RCP_W-1:0]   rcp_s2;
	logic [PROD_W-1:0]  prod;
	logic [QUO_W-1:0]   qest_s3, qest_s4;
	logic [QD_W-1:0]    qd_s4;
	logic [QD_W-1:0]    qd_plus;
	logic               bump;
	logic [QUO_W-1:0]   quo_s5;

	// floor(2^24 / d); entry zero is never used for a real quotient
	for (genvar i = 0; i < 2**CHAN_W; i++) begin : g_rcp
		localparam int unsigned DIVR = (i == 0) ? 1 : i;
		localparam logic [RCP_W-1:0] RCP = (i == 0) ? '0 : RCP_W'(RCP_ONE / DIVR);
		assign rcp_tab[i] = RCP;
	end

	always_ff @(posedge clk) begin
		if (en.tab) begin
			num_s2 <= num;
			den_s2 <= den;
			rcp_s2 <= rcp_tab[den];
		end
	end

	// estimate is the true quotient or one below it
	assign prod = PROD_W'(num_s2) * PROD_W'(rcp_s2);

	always_ff @(posedge clk) begin
		if (en.mul) begin
			qest_s3 <= prod[RCP_SHIFT +: QUO_W];
			num_s3  <= num_s2;
			den_s3  <= den_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en.chk) begin
			qd_s4   <= QD_W'(qest_s3) * QD_W'(den_s3);
			qest_s4 <= qest_s3;
			num_s4  <= num_s3;
			den_s4  <= den_s3;
		end
	end

	// remainder still holds a whole divisor
	assign qd_plus = qd_s4 + QD_W'(den_s4);
	assign bump    = QD_W'(num_s4) >= qd_plus;

	always_ff @(posedge clk) begin
		if (en.fix) begin
			quo_s5 <= qest_s4 + QUO_W'(bump);
		end
	end

	assign quo = quo_s5;

endmodule

`default_nettype wire

@@ sv/rgb_to_hsl_converter.sv @@
// rgb to hsl converter top level: min/max, two pipelined dividers, hue assembly
// depends on rhsl_pkg and rhsl_div
// pipeline: six register stages, s1 to s6; hsl_valid is the stage 6 valid bit
// throughput: one pixel per cycle unless the output stalls; each stage loads when
// empty or when the next stage moves, so a stalled output stops only full stages
// reset: arst_n clears the six stage valid bits; the data registers are not reset
`default_nettype none

module rgb_to_hsl_converter import rhsl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rgb_valid,
	output logic            rgb_ready,
	input  wire rgb_pixel_t rgb,
	output logic            hsl_valid,
	input  wire logic       hsl_ready,
	output hsl_pixel_t      hsl
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	logic [CHAN_W-1:0]        mx, mn;
	sector_t                  sector;
	logic signed [DIFF_W-1:0] diff;

	sector_t                  sector_s1, sector_s2, sector_s3, sector_s4, sector_s5;
	logic signed [DIFF_W-1:0] diff_s1;
	logic [CHAN_W-1:0]        delta_s1;
	logic [SUM_W-1:0]         sum_s1, sum_s2, sum_s3, sum_s4, sum_s5;
	logic                     neg_s2, neg_s3, neg_s4, neg_s5;
	logic                     gray_s2, gray_s3, gray_s4, gray_s5;

	logic [DIFF_W-1:0]        diff_abs;
	logic [DIV_N_W-1:0]       hue_num, sat_num;
	logic [SUM_W-1:0]         sum_inv, denom;
	div_en_t                  div_en;
	logic [QUO_W-1:0]         hue_quo, sat_quo;

	logic [HUE_W-1:0]         hue_ofs, hue;
	logic [SAT_W-1:0]         sat;
	hsl_pixel_t               hsl_s6;

	// ready ripples back from the output through full stages; an empty stage is ready
	assign adv6 = !vld_s6 || hsl_ready;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign rgb_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= rgb_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: extremes, sector and signed numerator
	always_comb begin
		mx = rgb.red;
		mn = rgb.red;
		if (rgb.green > mx) mx = rgb.green;
		if (rgb.blue > mx)  mx = rgb.blue;
		if (rgb.green < mn) mn = rgb.green;
		if (rgb.blue < mn)  mn = rgb.blue;
		// blue wins ties over green, green over red
		if (mx == rgb.blue) begin
			sector = SECTOR_BLUE;
			diff   = $signed({1'b0, rgb.red}) - $signed({1'b0, rgb.green});
		end else if (mx == rgb.green) begin
			sector = SECTOR_GREEN;
			diff   = $signed({1'b0, rgb.blue}) - $signed({1'b0, rgb.red});
		end else begin
			sector = SECTOR_RED;
			diff   = $signed({1'b0, rgb.green}) - $signed({1'b0, rgb.blue});
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			sector_s1 <= sector;
			diff_s1   <= diff;
			delta_s1  <= mx - mn;
			sum_s1    <= SUM_W'(mx) + SUM_W'(mn);
		end
	end

	// stage 2 inputs: divider numerators and saturation divisor
	assign diff_abs = diff_s1[DIFF_W-1] ? DIFF_W'(-diff_s1) : DIFF_W'(diff_s1);
	assign hue_num  = DIV_N_W'(diff_abs) * HUE_SECTOR_N;
	assign sat_num  = {delta_s1, SAT_FRAC_W'(0)};
	assign sum_inv  = SUM_MAX - sum_s1;
	assign denom    = (sum_s1 < sum_inv) ? sum_s1 : sum_inv;

	assign div_en = '{tab: adv2, mul: adv3, chk: adv4, fix: adv5};

	rhsl_div u_hue_div (
		.clk (clk),
		.en  (div_en),
		.num (hue_num),
		.den (delta_s1),
		.quo (hue_quo)
	);

	rhsl_div u_sat_div (
		.clk (clk),
		.en  (div_en),
		.num (sat_num),
		.den (denom[CHAN_W-1:0]),
		.quo (sat_quo)
	);

	// side data travels alongside the dividers
	always_ff @(posedge clk) begin
		if (adv2) begin
			sector_s2 <= sector_s1;
			neg_s2    <= diff_s1[DIFF_W-1];
			gray_s2   <= (delta_s1 == '0);
			sum_s2    <= sum_s1;
		end
		if (adv3) begin
			sector_s3 <= sector_s2;
			neg_s3    <= neg_s2;
			gray_s3   <= gray_s2;
			sum_s3    <= sum_s2;
		end
		if (adv4) begin
			sector_s4 <= sector_s3;
			neg_s4    <= neg_s3;
			gray_s4   <= gray_s3;
			sum_s4    <= sum_s3;
		end
		if (adv5) begin
			sector_s5 <= sector_s4;
			neg_s5    <= neg_s4;
			gray_s5   <= gray_s4;
			sum_s5    <= sum_s4;
		end
	end

	// stage 6: sector base plus signed offset, wrap negative red hues
	assign hue_ofs = HUE_W'(hue_quo[HUE_OFS_W-1:0]);

	always_comb begin
		case (sector_s5)
			SECTOR_RED: begin
				hue = (neg_s5 && hue_ofs != '0) ? HUE_FULL - hue_ofs : hue_ofs;
			end
			SECTOR_GREEN: begin
				hue = neg_s5 ? HUE_GREEN_BASE - hue_ofs : HUE_GREEN_BASE + hue_ofs;
			end
			SECTOR_BLUE: begin
				hue = neg_s5 ? HUE_BLUE_BASE - hue_ofs : HUE_BLUE_BASE + hue_ofs;
			end
			default: begin
				hue = '0;
			end
		endcase
		sat = sat_quo;
		if (gray_s5) begin
			hue = '0;
			sat = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			hsl_s6.hue_q6         <= hue;
			hsl_s6.saturation_q16 <= sat;
			hsl_s6.lightness_sum  <= sum_s5;
		end
	end

	assign hsl_valid = vld_s6;
	assign hsl       = hsl_s6;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> hsl.hue_q6 < HUE_FULL)
		else $error("hue outside one turn");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> hsl.saturation_q16 <= SAT_ONE)
		else $error("saturation above one");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(hsl_valid && hsl.saturation_q16 == '0) |-> hsl.hue_q6 == '0)
		else $error("zero saturation with nonzero hue");

	a_light_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> hsl.lightness_sum <= SUM_MAX)
		else $error("lightness sum out of range");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !vld_s6) |=> vld_s6)
		else $error("result lost on its way to the output register");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for rgb_to_hsl_converter: directed pixels, then random ones
// expected hsl: hand-computed or local predictor; depends on rhsl_pkg and the rtl

module testbench;
	import rhsl_pkg::*;

	// one stimulus row: pixel plus a hand-computed result where known is set
	typedef struct packed {
		logic       known;
		rgb_pixel_t px;
		hsl_pixel_t res;
	} pixel_row_t;

	localparam int NUM_DIRECTED = 25;
	localparam int NUM_RANDOM   = 1250;
	localparam int CALM_TAIL    = 200;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rgb_valid = 1'b0;
	logic       rgb_ready;
	rgb_pixel_t rgb = '0;
	logic       hsl_valid;
	logic       hsl_ready = 1'b0;
	hsl_pixel_t hsl;

	pixel_row_t pixel_list[$];
	hsl_pixel_t hsl_expected[$];
	int         n_items = 0;
	int         sent = 0;
	int         next_idx;
	int         send_gap = 0;
	int         sink_stall = 0;
	int         n_fail = 0;

	// red green blue | hue sat lightness
	pixel_row_t directed_rows [NUM_DIRECTED] = '{
		{1'b1, 8'd0,   8'd0,   8'd0,   15'd0,     17'd0,     9'd0},
		{1'b1, 8'd255, 8'd255, 8'd255, 15'd0,     17'd0,     9'd510},
		{1'b1, 8'd128, 8'd128, 8'd128, 15'd0,     17'd0,     9'd256},
		{1'b1, 8'd255, 8'd0,   8'd0,   15'd0,     17'd65536, 9'd255},
		{1'b1, 8'd0,   8'd255, 8'd0,   15'd7680,  17'd65536, 9'd255},
		{1'b1, 8'd0,   8'd0,   8'd255, 15'd15360, 17'd65536, 9'd255},
		{1'b1, 8'd255, 8'd255, 8'd0,   15'd3840,  17'd65536, 9'd255},
		{1'b1, 8'd0,   8'd255, 8'd255, 15'd11520, 17'd65536, 9'd255},
		{1'b1, 8'd255, 8'd0,   8'd255, 15'd19200, 17'd65536, 9'd255},
		{1'b1, 8'd255, 8'd0,   8'd1,   15'd23025, 17'd65536, 9'd255},
		{1'b1, 8'd1,   8'd0,   8'd0,   15'd0,     17'd65536, 9'd1},
		{1'b1, 8'd255, 8'd255, 8'd254, 15'd3840,  17'd65536, 9'd509},
		{1'b1, 8'd255, 8'd254, 8'd255, 15'd19200, 17'd65536, 9'd509},
		{1'b1, 8'd254, 8'd255, 8'd255, 15'd11520, 17'd65536, 9'd509},
		{1'b1, 8'd255, 8'd254, 8'd254, 15'd0,     17'd65536, 9'd509},
		{1'b0, 8'd200, 8'd100, 8'd50,  15'd0,     17'd0,     9'd0},
		{1'b0, 8'd10,  8'd20,  8'd30,  15'd0,     17'd0,     9'd0},
		{1'b0, 8'd30,  8'd20,  8'd10,  15'd0,     17'd0,     9'd0},
		{1'b0, 8'd100, 8'd150, 8'd101, 15'd0,     17'd0,     9'd0},
		{1'b0, 8'd128, 8'd127, 8'd127, 15'd0,     17'd0,     9'd0},
		{1'b0, 8'd129, 8'd128, 8'd128, 15'd0,     17'd0,     9'd0},
		{1'b0, 8'd127, 8'd128, 8'd129, 15'd0,     17'd0,     9'd0},
		{1'b0, 8'd170, 8'd85,  8'd0,   15'd0,     17'd0,     9'd0},
		{1'b0, 8'd90,  8'd160, 8'd220, 15'd0,     17'd0,     9'd0},
		{1'b0, 8'd1,   8'd254, 8'd128, 15'd0,     17'd0,     9'd0}
	};

	rgb_to_hsl_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb),
		.hsl_valid (hsl_valid),
		.hsl_ready (hsl_ready),
		.hsl       (hsl)
	);

	always #5 clk = ~clk;

	function automatic hsl_pixel_t hsl_of(input rgb_pixel_t p);
		int         r, g, b, hi, lo, span, total, hue, den, step;
		sector_t    sec;
		hsl_pixel_t o;
		r = p.red;
		g = p.green;
		b = p.blue;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		span = hi - lo;
		total = hi + lo;
		step = int'(HUE_SECTOR_N);
		hue = 0;
		o.saturation_q16 = '0;
		o.lightness_sum = SUM_W'(total);
		if (span != 0) begin
			// last matching channel wins on ties
			if (hi == b) sec = SECTOR_BLUE;
			else if (hi == g) sec = SECTOR_GREEN;
			else sec = SECTOR_RED;
			case (sec)
				SECTOR_BLUE: hue = int'(HUE_BLUE_BASE) + (step * (r - g)) / span;
				SECTOR_GREEN: hue = int'(HUE_GREEN_BASE) + (step * (b - r)) / span;
				default: begin
					hue = (step * (g - b)) / span;
					if (hue < 0) hue += int'(HUE_FULL);
				end
			endcase
			den = (total < int'(SUM_MAX) - total) ? total : int'(SUM_MAX) - total;
			o.saturation_q16 = SAT_W'((span << SAT_FRAC_W) / den);
		end
		o.hue_q6 = HUE_W'(hue);
		return o;
	endfunction

	function automatic rgb_pixel_t random_pixel();
		rgb_pixel_t p;
		logic [7:0] a, c;
		int         k;
		p.red = 8'($urandom_range(0, 255));
		p.green = 8'($urandom_range(0, 255));
		p.blue = 8'($urandom_range(0, 255));
		a = 8'($urandom_range(0, 255));
		k = $urandom_range(0, 2);
		case ($urandom_range(0, 9))
			4: p = {a, a, a};
			5: begin
				// two channels tie, the third is free
				c = 8'($urandom_range(0, 255));
				p = {a, a, a};
				if (k == 0) p.red = c;
				else if (k == 1) p.green = c;
				else p.blue = c;
			end
			6: begin
				c = (a > 8'd250) ? 8'd250 : a;
				p.red = c + 8'($urandom_range(0, 4));
				p.green = c + 8'($urandom_range(0, 4));
				p.blue = c + 8'($urandom_range(0, 4));
			end
			7: begin
				p.red = $urandom_range(0, 1) ? 8'($urandom_range(254, 255)) : 8'($urandom_range(0, 1));
				p.green = $urandom_range(0, 1) ? 8'($urandom_range(254, 255)) : 8'($urandom_range(0, 1));
				p.blue = $urandom_range(0, 1) ? 8'($urandom_range(254, 255)) : 8'($urandom_range(0, 1));
			end
			8: begin
				p.red = 8'($urandom_range(200, 255));
				p.green = 8'($urandom_range(200, 255));
				p.blue = 8'($urandom_range(200, 255));
			end
			9: begin
				p.red = 8'($urandom_range(0, 50));
				p.green = 8'($urandom_range(0, 50));
				p.blue = 8'($urandom_range(0, 50));
			end
			default: ;
		endcase
		return p;
	endfunction

	// no idling near the end and in one of every four stretches of items
	function automatic bit calm(input int i);
		return (i + CALM_TAIL >= n_items) || (i % 256 >= 192);
	endfunction

	// pixel source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_valid <= 1'b0;
			rgb <= '0;
			sent <= 0;
			send_gap <= 0;
		end else begin
			next_idx = sent + ((rgb_valid && rgb_ready) ? 1 : 0);
			if (rgb_valid && !rgb_ready) begin
				// hold until the transfer
			end else if (send_gap != 0) begin
				rgb_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (next_idx < n_items) begin
				if (!calm(next_idx) && $urandom_range(0, 5) == 0) begin
					rgb_valid <= 1'b0;
					send_gap <= $urandom_range(0, 18);
				end else begin
					rgb_valid <= 1'b1;
					rgb <= pixel_list[next_idx].px;
				end
			end else begin
				rgb_valid <= 1'b0;
			end
			sent <= next_idx;
		end
	end

	// result sink with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsl_ready <= 1'b0;
			sink_stall <= 0;
		end else if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
		end else if (!calm(sent) && $urandom_range(0, 7) == 0) begin
			hsl_ready <= 1'b0;
			sink_stall <= $urandom_range(0, 18);
		end else begin
			hsl_ready <= 1'b1;
		end
	end

	// queue the expected result of every input transfer
	always @(posedge clk) begin
		if (arst_n && rgb_valid && rgb_ready) begin
			if (pixel_list[sent].known) hsl_expected.push_back(pixel_list[sent].res);
			else hsl_expected.push_back(hsl_of(pixel_list[sent].px));
		end
	end

	always @(posedge clk) begin : check_output
		hsl_pixel_t want;
		if (arst_n && hsl_valid && hsl_ready) begin
			if (hsl_expected.size() == 0) begin
				$error("result transfer with nothing expected: hue_q6 %0d", hsl.hue_q6);
				n_fail++;
			end else begin
				want = hsl_expected.pop_front();
				if (hsl.hue_q6 !== want.hue_q6) begin
					$error("hue_q6: expected %0d, got %0d", want.hue_q6, hsl.hue_q6);
					n_fail++;
				end
				if (hsl.saturation_q16 !== want.saturation_q16) begin
					$error("saturation_q16: expected %0d, got %0d",
						want.saturation_q16, hsl.saturation_q16);
					n_fail++;
				end
				if (hsl.lightness_sum !== want.lightness_sum) begin
					$error("lightness_sum: expected %0d, got %0d",
						want.lightness_sum, hsl.lightness_sum);
					n_fail++;
				end
			end
		end
	end

	initial begin
		pixel_row_t row;
		foreach (directed_rows[i]) pixel_list.push_back(directed_rows[i]);
		for (int i = 0; i < NUM_RANDOM; i++) begin
			row = '0;
			row.px = random_pixel();
			pixel_list.push_back(row);
		end
		n_items = pixel_list.size();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (sent < n_items) @(posedge clk);
		while (hsl_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_fail == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/rhsl_pkg.sv
sv/rhsl_div.sv
sv/rgb_to_hsl_converter.sv
test/testbench.sv
